// ----- hw/rtl/uer_pkg.sv -----
// Shared types and constants for the ultrasonic echo ranger.
// Holds the phase and status codes, the register map and the result record.
// No dependencies.
`timescale 1ns / 1ps

package uer_pkg;

  localparam int TICK_W     = 20;
  localparam int SETUP_W    = 10;
  localparam int PULSE_W    = 10;
  localparam int SETTLE_W   = 16;
  localparam int SCALE_W    = 16;
  localparam int FRAC_W     = 16;
  localparam int DIST_W     = 16;
  localparam int MIN_W      = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [MIN_W-1:0]    MIN_RESET       = 20'd999000;
  localparam logic [SETUP_W-1:0]  SETUP_RESET     = 10'd10;
  localparam logic [PULSE_W-1:0]  PULSE_RESET     = 10'd5;
  localparam logic [SETTLE_W-1:0] SETTLE_RESET    = 16'd500;
  localparam logic [TICK_W-1:0]   TIMEOUT_RESET   = 20'd100000;
  localparam logic [SCALE_W-1:0]  SCALE_RESET     = 16'd11151;
  localparam logic [DIST_W-1:0]   RANGE_RESET     = 16'd3000;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SETUP,
    PH_PULSE,
    PH_SETTLE,
    PH_WRISE,
    PH_WFALL
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_RANGE,
    ST_NORISE,
    ST_NOFALL
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SETUP,
    CFG_PULSE,
    CFG_SETTLE,
    CFG_TIMEOUT,
    CFG_SCALE,
    CFG_RANGE
  } cfg_idx_t;

  typedef struct packed {
    logic [SETUP_W-1:0]  setup_ticks;
    logic [PULSE_W-1:0]  pulse_ticks;
    logic [SETTLE_W-1:0] settle_ticks;
    logic [TICK_W-1:0]   timeout_ticks;
    logic [SCALE_W-1:0]  scale_q16;
    logic [DIST_W-1:0]   range_limit_mm;
  } cfg_t;

  typedef struct packed {
    logic               trigger_level;
    logic               busy_res;
    logic               done_res;
    status_t            status;
    logic [DIST_W-1:0]  distance_mm;
    logic [MIN_W-1:0]   min_mm;
    logic [DIST_W-1:0]  max_mm;
  } res_t;

  // A setup, pulse or settle phase with a zero length is skipped on entry.
  function automatic phase_t skip_empty(phase_t p, cfg_t c);
    phase_t q;
    q = p;
    if (q == PH_SETUP && c.setup_ticks == '0) q = PH_PULSE;
    if (q == PH_PULSE && c.pulse_ticks == '0) q = PH_SETTLE;
    if (q == PH_SETTLE && c.settle_ticks == '0) q = PH_WRISE;
    return q;
  endfunction

endpackage

// ----- hw/rtl/uer_cfg.sv -----
// Configuration register file of the ultrasonic echo ranger.
// Depends on uer_pkg for the register map and the cfg_t record.
`timescale 1ns / 1ps

module uer_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [uer_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [uer_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output uer_pkg::cfg_t                    cfg
);

  uer_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (uer_pkg::cfg_idx_t'(cfg_index))
        uer_pkg::CFG_SETUP:   cfg_nxt.setup_ticks    = cfg_wdata[uer_pkg::SETUP_W-1:0];
        uer_pkg::CFG_PULSE:   cfg_nxt.pulse_ticks    = cfg_wdata[uer_pkg::PULSE_W-1:0];
        uer_pkg::CFG_SETTLE:  cfg_nxt.settle_ticks   = cfg_wdata[uer_pkg::SETTLE_W-1:0];
        uer_pkg::CFG_TIMEOUT: cfg_nxt.timeout_ticks  = cfg_wdata[uer_pkg::TICK_W-1:0];
        uer_pkg::CFG_SCALE:   cfg_nxt.scale_q16      = cfg_wdata[uer_pkg::SCALE_W-1:0];
        uer_pkg::CFG_RANGE:   cfg_nxt.range_limit_mm = cfg_wdata[uer_pkg::DIST_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setup_ticks    <= uer_pkg::SETUP_RESET;
      cfg_r.pulse_ticks    <= uer_pkg::PULSE_RESET;
      cfg_r.settle_ticks   <= uer_pkg::SETTLE_RESET;
      cfg_r.timeout_ticks  <= uer_pkg::TIMEOUT_RESET;
      cfg_r.scale_q16      <= uer_pkg::SCALE_RESET;
      cfg_r.range_limit_mm <= uer_pkg::RANGE_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- hw/rtl/uer_core.sv -----
// Measurement sequencer and distance datapath of the ultrasonic echo ranger.
// Depends on uer_pkg; state advances once per tick transfer (fire).
`timescale 1ns / 1ps

module uer_core #(
  parameter int COUNT_WIDTH = 20
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           fire,
  input  logic           operation,
  input  logic           echo_level,
  input  uer_pkg::cfg_t  cfg,
  output uer_pkg::res_t  res
);

  localparam int ACC_W = COUNT_WIDTH + uer_pkg::FRAC_W;

  uer_pkg::phase_t                phase_r, phase_nxt, eff_phase;
  logic [uer_pkg::TICK_W-1:0]     ticks_r, ticks_nxt, eff_ticks, tick_inc;
  logic [uer_pkg::TICK_W-1:0]     setup_lim, pulse_lim, settle_lim, wait_lim;
  logic [COUNT_WIDTH-1:0]         width_r, width_nxt, width_inc, dist_wide;
  logic [ACC_W-1:0]               acc_r, acc_nxt, acc_inc;
  logic                           prev_r;
  logic [uer_pkg::MIN_W-1:0]      min_r, min_nxt;
  logic [uer_pkg::DIST_W-1:0]     max_r, max_nxt, dist16;
  logic                           start_now, rise, fall, timeout_hit, width_full, in_range;
  logic                           trig, done;
  uer_pkg::status_t               status;
  logic [uer_pkg::DIST_W-1:0]     dist_out;

  // A start in idle makes this tick the first tick of setup or of a later phase if setup is empty.
  assign start_now = (phase_r == uer_pkg::PH_IDLE) && operation;
  assign eff_phase = start_now ? uer_pkg::skip_empty(uer_pkg::PH_SETUP, cfg) : phase_r;
  assign eff_ticks = start_now ? '0 : ticks_r;
  assign tick_inc  = eff_ticks + {{(uer_pkg::TICK_W-1){1'b0}}, 1'b1};

  assign setup_lim  = {{(uer_pkg::TICK_W-uer_pkg::SETUP_W){1'b0}}, cfg.setup_ticks};
  assign pulse_lim  = {{(uer_pkg::TICK_W-uer_pkg::PULSE_W){1'b0}}, cfg.pulse_ticks};
  assign settle_lim = {{(uer_pkg::TICK_W-uer_pkg::SETTLE_W){1'b0}}, cfg.settle_ticks};
  // A zero timeout behaves as one tick.
  assign wait_lim   = (cfg.timeout_ticks == '0) ? {{(uer_pkg::TICK_W-1){1'b0}}, 1'b1}
                                                 : cfg.timeout_ticks;
  assign timeout_hit = tick_inc >= wait_lim;

  assign rise = echo_level && !prev_r;
  assign fall = !echo_level && prev_r;

  // The running product width*scale grows by one scale step per echo tick,
  // so the distance needs an adder here rather than a multiplier.
  assign width_full = &width_r;
  assign width_inc  = width_full ? width_r : width_r + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
  assign acc_inc    = width_full ? acc_r
                                 : acc_r + {{COUNT_WIDTH{1'b0}}, cfg.scale_q16};
  assign dist_wide  = acc_inc[ACC_W-1 -: COUNT_WIDTH];
  assign dist16     = dist_wide[uer_pkg::DIST_W-1:0];
  assign in_range   = (dist_wide != '0) &&
                      (dist_wide < {{(COUNT_WIDTH-uer_pkg::DIST_W){1'b0}}, cfg.range_limit_mm});

  // Next phase and phase tick count.
  always_comb begin
    phase_nxt = eff_phase;
    ticks_nxt = tick_inc;
    unique case (eff_phase)
      uer_pkg::PH_IDLE: begin
        ticks_nxt = '0;
      end
      uer_pkg::PH_SETUP: begin
        if (tick_inc >= setup_lim) begin
          phase_nxt = uer_pkg::skip_empty(uer_pkg::PH_PULSE, cfg);
          ticks_nxt = '0;
        end
      end
      uer_pkg::PH_PULSE: begin
        if (tick_inc >= pulse_lim) begin
          phase_nxt = uer_pkg::skip_empty(uer_pkg::PH_SETTLE, cfg);
          ticks_nxt = '0;
        end
      end
      uer_pkg::PH_SETTLE: begin
        if (tick_inc >= settle_lim) begin
          phase_nxt = uer_pkg::PH_WRISE;
          ticks_nxt = '0;
        end
      end
      uer_pkg::PH_WRISE: begin
        if (rise) begin
          phase_nxt = uer_pkg::PH_WFALL;
          ticks_nxt = '0;
        end else if (timeout_hit) begin
          phase_nxt = uer_pkg::PH_IDLE;
          ticks_nxt = '0;
        end
      end
      uer_pkg::PH_WFALL: begin
        if (fall || timeout_hit) begin
          phase_nxt = uer_pkg::PH_IDLE;
          ticks_nxt = '0;
        end
      end
      default: begin
        phase_nxt = uer_pkg::PH_IDLE;
        ticks_nxt = '0;
      end
    endcase
  end

  // Result fields and datapath state.
  always_comb begin
    trig      = (eff_phase == uer_pkg::PH_PULSE);
    done      = 1'b0;
    status    = uer_pkg::ST_OK;
    dist_out  = '0;
    width_nxt = width_r;
    acc_nxt   = acc_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    unique case (eff_phase)
      uer_pkg::PH_WRISE: begin
        if (rise) begin
          width_nxt = '0;
          acc_nxt   = '0;
        end else if (timeout_hit) begin
          done   = 1'b1;
          status = uer_pkg::ST_NORISE;
        end
      end
      uer_pkg::PH_WFALL: begin
        width_nxt = width_inc;
        acc_nxt   = acc_inc;
        if (fall) begin
          done = 1'b1;
          if (in_range) begin
            dist_out = dist16;
            if ({{(uer_pkg::MIN_W-uer_pkg::DIST_W){1'b0}}, dist16} < min_r) begin
              min_nxt = {{(uer_pkg::MIN_W-uer_pkg::DIST_W){1'b0}}, dist16};
            end
            if (dist16 > max_r) max_nxt = dist16;
          end else begin
            status = uer_pkg::ST_RANGE;
          end
        end else if (timeout_hit) begin
          done   = 1'b1;
          status = uer_pkg::ST_NOFALL;
        end
      end
      default: begin
        done = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= uer_pkg::PH_IDLE;
      ticks_r <= '0;
      width_r <= '0;
      acc_r   <= '0;
      prev_r  <= 1'b0;
      min_r   <= uer_pkg::MIN_RESET;
      max_r   <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      ticks_r <= ticks_nxt;
      width_r <= width_nxt;
      acc_r   <= acc_nxt;
      prev_r  <= echo_level;
      min_r   <= min_nxt;
      max_r   <= max_nxt;
    end
  end

  always_comb begin
    res.trigger_level = trig;
    res.busy_res      = (phase_nxt != uer_pkg::PH_IDLE);
    res.done_res      = done;
    res.status        = status;
    res.distance_mm   = dist_out;
    res.min_mm        = min_nxt;
    res.max_mm        = max_nxt;
  end

  a_max_grows: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> (max_r >= $past(max_r)))
    else $error("uer_core: maximum distance went down");

  a_min_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> (min_r <= $past(min_r)))
    else $error("uer_core: minimum distance went up");

  a_idle_ticks: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == uer_pkg::PH_IDLE) |-> (ticks_r == '0))
    else $error("uer_core: tick count left over in idle");

endmodule

// ----- hw/rtl/ultrasonic_echo_ranger.sv -----
// Top level of the ultrasonic echo ranger: input register, sequencer, result register.
// Depends on uer_pkg, uer_cfg and uer_core.
//
//   Channel  Ports                                     Direction  Transfer when
//   in       in_valid, in_stall, in_operation,         input      in_valid && !in_stall
//            in_echo_level
//   out      out_valid, out_stall, out_trigger_level,  output     out_valid && !out_stall
//            out_busy_res, out_done_res, out_status,
//            out_distance_mm, out_min_mm, out_max_mm
//   cfg      cfg_we, cfg_index, cfg_wdata              input      cfg_we
//
// One tick item is taken every clock cycle while in_stall is low; its result is
// offered once the item has passed through the input register and moved into the
// result register.
// The echo width is turned into millimeters by a running sum of the scale, so
// the longest path is one adder of COUNT_WIDTH+16 bits and the range compare.
// Reset (synchronous, rst_n low) returns the sequencer to idle, sets the register
// file to its defaults, and clears the minimum to 999000 and the maximum to 0.
// A stall on the result side holds the result register and, once the input
// register is also full, raises in_stall in the same cycle.
`timescale 1ns / 1ps

module ultrasonic_echo_ranger #(
  parameter int COUNT_WIDTH = 20
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_operation,
  input  logic                              in_echo_level,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_trigger_level,
  output logic                              out_busy_res,
  output logic                              out_done_res,
  output logic [1:0]                        out_status,
  output logic [uer_pkg::DIST_W-1:0]        out_distance_mm,
  output logic [uer_pkg::MIN_W-1:0]         out_min_mm,
  output logic [uer_pkg::DIST_W-1:0]        out_max_mm,
  input  logic                              cfg_we,
  input  logic [uer_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [uer_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  uer_pkg::cfg_t cfg;
  uer_pkg::res_t res;
  uer_pkg::res_t res_r;

  logic s1_valid_r, s1_valid_nxt;
  logic s1_op_r, s1_echo_r;
  logic out_valid_r, out_valid_nxt;
  logic out_free, fire, in_take;

  // The result register can take a new result when it is empty or is being
  // drained this cycle; the item in the input register moves on exactly then.
  assign out_free = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  assign s1_valid_nxt  = in_take ? 1'b1 : (fire ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = out_free ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r   <= in_operation;
      s1_echo_r <= in_echo_level;
    end
    if (fire) begin
      res_r <= res;
    end
  end

  uer_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  uer_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .operation  (s1_op_r),
    .echo_level (s1_echo_r),
    .cfg        (cfg),
    .res        (res)
  );

  assign out_valid         = out_valid_r;
  assign out_trigger_level = res_r.trigger_level;
  assign out_busy_res      = res_r.busy_res;
  assign out_done_res      = res_r.done_res;
  assign out_status        = res_r.status;
  assign out_distance_mm   = res_r.distance_mm;
  assign out_min_mm        = res_r.min_mm;
  assign out_max_mm        = res_r.max_mm;

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_done_res) |-> !out_busy_res)
    else $error("ultrasonic_echo_ranger: finished measurement still busy");

  a_quiet_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_done_res) |->
      (out_status == uer_pkg::ST_OK && out_distance_mm == '0))
    else $error("ultrasonic_echo_ranger: status or distance without a finish");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("ultrasonic_echo_ranger: input stalled with room to spare");

endmodule
